// File: rtl/core/scfh_pkg.sv
// Package with shared types and constants of the serial command frame handler.
`default_nettype none

package scfh_pkg;

    localparam int BUF_DEPTH_DEF = 32;
    localparam int VAR_COUNT_DEF = 256;

    localparam logic [7:0] ECHO_OP = 8'hFE;

    localparam logic [1:0] REQ_RX     = 2'd0;
    localparam logic [1:0] REQ_VAR_WR = 2'd1;
    localparam logic [1:0] REQ_VAR_RD = 2'd2;

    localparam logic [2:0] CFG_DEVICE_TYPE  = 3'd0;
    localparam logic [2:0] CFG_OP_IDENTIFY  = 3'd1;
    localparam logic [2:0] CFG_OP_RESET     = 3'd2;
    localparam logic [2:0] CFG_OP_VAR_WRITE = 3'd3;
    localparam logic [2:0] CFG_OP_VAR_READ  = 3'd4;
    localparam logic [2:0] CFG_OP_ID_WRITE  = 3'd5;
    localparam logic [2:0] CFG_ERROR_BYTE   = 3'd6;

    localparam logic [2:0] RPL_IDENT    = 3'd0;
    localparam logic [2:0] RPL_RESET    = 3'd1;
    localparam logic [2:0] RPL_VWRITE   = 3'd2;
    localparam logic [2:0] RPL_VREAD    = 3'd3;
    localparam logic [2:0] RPL_IDWRITE  = 3'd4;
    localparam logic [2:0] RPL_ECHO     = 3'd5;
    localparam logic [2:0] RPL_ERROR    = 3'd6;
    localparam logic [2:0] RPL_LOCAL_RD = 3'd7;

    typedef struct packed {
        logic load;
        logic exec;
        logic apply;
        logic fetch;
        logic push;
    } scfh_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       frame_done;
        logic       reply_last;
        logic       out_free;
    } scfh_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/serial_command_frame_handler.sv
// Top level of the serial command frame handler.
//
//  Channel  Direction  Signals                              Payload
//  s_*      in         s_tvalid s_tready s_tdata s_tuser    rx byte, slot, value; request type
//  m_*      out        m_tvalid m_tready m_tdata m_tuser    reply or read byte; kind; m_tlast
//  cfg_*    in         cfg_we cfg_index cfg_data            register writes, no handshake
//
// A local write or a frame byte that completes no frame runs load and execute.
// A local read adds fetch and push; a completed frame adds apply, then fetch
// and push per reply byte, issuing one buffer or store read per byte.
// Reset clears receive state, device id and variable valid bits, and presets config registers.
// Input is taken only while the controller is idle; a stalled output holds the
// controller in the push step until the output register frees.
`default_nettype none

module serial_command_frame_handler #(
    parameter int BUF_DEPTH = scfh_pkg::BUF_DEPTH_DEF,
    parameter int VAR_COUNT = scfh_pkg::VAR_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte[7:0], var_index[15:8], var_value[23:16]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tuser,   // out_kind[0]
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    scfh_pkg::scfh_cmd_t  cmd;
    scfh_pkg::scfh_stat_t stat;

    scfh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    scfh_dp #(
        .BUF_DEPTH (BUF_DEPTH),
        .VAR_COUNT (VAR_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_req    (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_index  (s_tdata[15:8]),
        .in_value  (s_tdata[23:16]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/scfh_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module scfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/scfh_dp.sv
// Datapath: receive state, variable store, command decode and reply output register.
`default_nettype none

module scfh_dp #(
    parameter int BUF_DEPTH = scfh_pkg::BUF_DEPTH_DEF,
    parameter int VAR_COUNT = scfh_pkg::VAR_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scfh_pkg::scfh_cmd_t cmd,
    output scfh_pkg::scfh_stat_t    stat,
    input  wire logic [1:0]         in_req,
    input  wire logic [7:0]         in_byte,
    input  wire logic [7:0]         in_index,
    input  wire logic [7:0]         in_value,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);

    localparam int FB_AW  = $clog2(BUF_DEPTH);
    localparam int FB_CW  = $clog2(BUF_DEPTH + 1);
    localparam int KW     = $clog2(BUF_DEPTH + 2);
    localparam int VAR_AW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    logic [15:0] device_type_reg;
    logic [7:0]  op_identify_reg, op_reset_reg, op_var_write_reg;
    logic [7:0]  op_var_read_reg, op_id_write_reg, error_byte_reg;

    logic [1:0]  req_reg;
    logic [7:0]  byte_reg, index_reg, value_reg;

    logic [FB_CW-1:0] count_reg;
    logic [8:0]       rem_reg;
    logic [7:0]       cmd_byte_reg, buf2_reg, buf3_reg;
    logic [15:0]      device_id_reg;
    logic [VAR_COUNT-1:0] var_valid_reg;

    logic [2:0]  kind_reg;
    logic [KW-1:0] k_reg;

    logic        out_valid_reg, out_kind_reg, out_last_reg;
    logic [7:0]  out_byte_reg;

    logic        is_len, has_room, frame_done, out_free, clear_rx;
    logic [8:0]  rem_a, rem_b;
    logic [2:0]  decoded;
    logic        local_wr, local_rd, frame_var_wr;
    logic        idx_in_range, buf2_in_range, rd_in_range;
    logic [7:0]  rd_index;
    logic [KW-1:0] last_k, k_minus_1;
    logic        reply_last;
    logic [7:0]  reply_byte, var_value_ok;

    logic               fb_we, fb_re;
    logic [FB_AW-1:0]   fb_addr;
    logic [7:0]         fb_rdata;
    logic               vs_we, vs_re;
    logic [VAR_AW-1:0]  vs_addr;
    logic [7:0]         vs_wdata, vs_rdata;

    assign is_len     = (count_reg == FB_CW'(1));
    assign has_room   = (count_reg < FB_CW'(BUF_DEPTH));
    assign rem_a      = is_len ? ({1'b0, byte_reg} + 9'd1) : rem_reg;
    assign rem_b      = (rem_a != 9'd0) ? (rem_a - 9'd1) : 9'd0;
    assign frame_done = (rem_b == 9'd0);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        priority if (cmd_byte_reg == op_identify_reg)
        begin
            decoded = scfh_pkg::RPL_IDENT;
        end
        else if (cmd_byte_reg == op_reset_reg)
        begin
            decoded = scfh_pkg::RPL_RESET;
        end
        else if (cmd_byte_reg == op_var_write_reg)
        begin
            decoded = scfh_pkg::RPL_VWRITE;
        end
        else if (cmd_byte_reg == op_var_read_reg)
        begin
            decoded = scfh_pkg::RPL_VREAD;
        end
        else if (cmd_byte_reg == op_id_write_reg)
        begin
            decoded = scfh_pkg::RPL_IDWRITE;
        end
        else if (cmd_byte_reg == scfh_pkg::ECHO_OP)
        begin
            decoded = scfh_pkg::RPL_ECHO;
        end
        else
        begin
            decoded = scfh_pkg::RPL_ERROR;
        end
    end

    assign idx_in_range  = ({1'b0, index_reg} < 9'(VAR_COUNT));
    assign buf2_in_range = ({1'b0, buf2_reg} < 9'(VAR_COUNT));
    assign local_wr      = cmd.exec && (req_reg == scfh_pkg::REQ_VAR_WR);
    assign local_rd      = cmd.exec && (req_reg == scfh_pkg::REQ_VAR_RD);
    assign frame_var_wr  = cmd.apply && (decoded == scfh_pkg::RPL_VWRITE);

    assign rd_index    = (kind_reg == scfh_pkg::RPL_LOCAL_RD) ? index_reg : buf2_reg;
    assign rd_in_range = ({1'b0, rd_index} < 9'(VAR_COUNT));

    // Variable store: one port, shared by local writes, frame writes and reads.
    always_comb
    begin
        vs_we    = (local_wr && idx_in_range) || (frame_var_wr && buf2_in_range);
        vs_re    = cmd.fetch;
        vs_wdata = local_wr ? value_reg : buf3_reg;
        if (local_wr)
        begin
            vs_addr = index_reg[VAR_AW-1:0];
        end
        else if (cmd.apply)
        begin
            vs_addr = buf2_reg[VAR_AW-1:0];
        end
        else
        begin
            vs_addr = rd_index[VAR_AW-1:0];
        end
    end

    scfh_ram #(
        .WIDTH (8),
        .DEPTH (VAR_COUNT)
    ) u_var_ram (
        .clk   (clk),
        .we    (vs_we),
        .re    (vs_re),
        .addr  (vs_addr),
        .wdata (vs_wdata),
        .rdata (vs_rdata)
    );

    // Frame buffer: data read from entries at or above the fill count never goes into a reply.
    assign k_minus_1 = k_reg - KW'(1);
    assign fb_we     = cmd.exec && (req_reg == scfh_pkg::REQ_RX) && has_room;
    assign fb_re     = cmd.fetch;
    assign fb_addr   = cmd.exec ? count_reg[FB_AW-1:0] : k_minus_1[FB_AW-1:0];

    scfh_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fb_we),
        .re    (fb_re),
        .addr  (fb_addr),
        .wdata (byte_reg),
        .rdata (fb_rdata)
    );

    assign var_value_ok = (rd_in_range && var_valid_reg[rd_index[VAR_AW-1:0]]) ? vs_rdata : 8'd0;

    always_comb
    begin
        unique case (kind_reg)
            scfh_pkg::RPL_IDENT:   last_k = KW'(4);
            scfh_pkg::RPL_VWRITE:  last_k = KW'(1);
            scfh_pkg::RPL_VREAD:   last_k = KW'(2);
            scfh_pkg::RPL_IDWRITE: last_k = KW'(2);
            scfh_pkg::RPL_ECHO:    last_k = KW'(count_reg);
            default:               last_k = KW'(0);
        endcase
    end

    assign reply_last = (k_reg == last_k);

    always_comb
    begin
        reply_byte = 8'd0;
        unique case (kind_reg)
            scfh_pkg::RPL_IDENT:
            begin
                unique case (k_reg)
                    KW'(0):  reply_byte = 8'd4;
                    KW'(1):  reply_byte = device_id_reg[15:8];
                    KW'(2):  reply_byte = device_id_reg[7:0];
                    KW'(3):  reply_byte = device_type_reg[15:8];
                    default: reply_byte = device_type_reg[7:0];
                endcase
            end
            scfh_pkg::RPL_RESET:
            begin
                reply_byte = 8'd0;
            end
            scfh_pkg::RPL_VWRITE:
            begin
                if (k_reg == KW'(0))
                begin
                    reply_byte = 8'd1;
                end
                else
                begin
                    reply_byte = buf2_in_range ? buf3_reg : 8'd0;
                end
            end
            scfh_pkg::RPL_VREAD:
            begin
                unique case (k_reg)
                    KW'(0):  reply_byte = 8'd2;
                    KW'(1):  reply_byte = buf2_reg;
                    default: reply_byte = var_value_ok;
                endcase
            end
            scfh_pkg::RPL_IDWRITE:
            begin
                unique case (k_reg)
                    KW'(0):  reply_byte = 8'd2;
                    KW'(1):  reply_byte = device_id_reg[15:8];
                    default: reply_byte = device_id_reg[7:0];
                endcase
            end
            scfh_pkg::RPL_ECHO:
            begin
                reply_byte = (k_reg == KW'(0)) ? 8'(count_reg) : fb_rdata;
            end
            scfh_pkg::RPL_ERROR:
            begin
                reply_byte = error_byte_reg;
            end
            default:
            begin
                reply_byte = var_value_ok;
            end
        endcase
    end

    assign clear_rx = cmd.push && reply_last && (kind_reg != scfh_pkg::RPL_LOCAL_RD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_type_reg  <= 16'd0;
            op_identify_reg  <= 8'd1;
            op_reset_reg     <= 8'd2;
            op_var_write_reg <= 8'd3;
            op_var_read_reg  <= 8'd4;
            op_id_write_reg  <= 8'd5;
            error_byte_reg   <= 8'hFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scfh_pkg::CFG_DEVICE_TYPE:  device_type_reg  <= cfg_data;
                scfh_pkg::CFG_OP_IDENTIFY:  op_identify_reg  <= cfg_data[7:0];
                scfh_pkg::CFG_OP_RESET:     op_reset_reg     <= cfg_data[7:0];
                scfh_pkg::CFG_OP_VAR_WRITE: op_var_write_reg <= cfg_data[7:0];
                scfh_pkg::CFG_OP_VAR_READ:  op_var_read_reg  <= cfg_data[7:0];
                scfh_pkg::CFG_OP_ID_WRITE:  op_id_write_reg  <= cfg_data[7:0];
                scfh_pkg::CFG_ERROR_BYTE:   error_byte_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= in_req;
            byte_reg  <= in_byte;
            index_reg <= in_index;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rem_reg       <= 9'd2;
            cmd_byte_reg  <= 8'd0;
            buf2_reg      <= 8'd0;
            buf3_reg      <= 8'd0;
            device_id_reg <= 16'd0;
            var_valid_reg <= '0;
            kind_reg      <= scfh_pkg::RPL_ERROR;
            k_reg         <= '0;
        end
        else
        begin
            if (cmd.exec && (req_reg == scfh_pkg::REQ_RX))
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + FB_CW'(1);
                    if (count_reg == FB_CW'(0))
                    begin
                        cmd_byte_reg <= byte_reg;
                    end
                    if (count_reg == FB_CW'(2))
                    begin
                        buf2_reg <= byte_reg;
                    end
                    if (count_reg == FB_CW'(3))
                    begin
                        buf3_reg <= byte_reg;
                    end
                end
                rem_reg <= rem_b;
            end
            if (vs_we)
            begin
                var_valid_reg[vs_addr] <= 1'b1;
            end
            if (local_rd)
            begin
                kind_reg <= scfh_pkg::RPL_LOCAL_RD;
                k_reg    <= '0;
            end
            if (cmd.apply)
            begin
                kind_reg <= decoded;
                k_reg    <= '0;
                if (decoded == scfh_pkg::RPL_IDWRITE)
                begin
                    device_id_reg <= {buf2_reg, buf3_reg};
                end
            end
            if (cmd.push && !reply_last)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (clear_rx)
            begin
                count_reg    <= '0;
                rem_reg      <= 9'd2;
                cmd_byte_reg <= 8'd0;
                buf2_reg     <= 8'd0;
                buf3_reg     <= 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_byte_reg <= reply_byte;
            out_kind_reg <= (kind_reg == scfh_pkg::RPL_LOCAL_RD);
            out_last_reg <= reply_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign stat.req_type   = req_reg;
    assign stat.frame_done = frame_done;
    assign stat.reply_last = reply_last;
    assign stat.out_free   = out_free;

    a_push_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || m_tready))
        else $error("reply byte pushed over a pending output transaction");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FB_CW'(BUF_DEPTH))
        else $error("frame byte count above buffer depth");

    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (req_reg == scfh_pkg::REQ_RX)) |-> (rem_reg != 9'd0))
        else $error("remaining frame byte count reached zero without a reply");

    a_rx_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        clear_rx |=> ((count_reg == '0) && (rem_reg == 9'd2) && m_tlast))
        else $error("receive state not cleared after the last reply byte");

endmodule

`default_nettype wire

// File: rtl/core/scfh_ctrl.sv
// Controller state machine that sequences input handling and reply bytes.
`default_nettype none

module scfh_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output scfh_pkg::scfh_cmd_t       cmd,
    input  wire scfh_pkg::scfh_stat_t stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_APPLY = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.req_type == scfh_pkg::REQ_VAR_RD)
                begin
                    state_next = ST_FETCH;
                end
                else if ((stat.req_type == scfh_pkg::REQ_RX) && stat.frame_done)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = stat.reply_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
